>>> rtl/cvs_pkg.sv
`default_nettype none

package cvs_pkg;

  // Fixed field widths of the block's words.
  localparam int CLS_W      = 6;
  localparam int SCORE_W    = 16;
  localparam int MV_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOC_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THR  = 2'd2;

  // Register values after reset (0.85 and 0.90 in Q0.16).
  localparam logic [SCORE_W-1:0] LOC_THR_RST   = 16'd55706;
  localparam logic [MV_W-1:0]    MIN_VOTES_RST = 4'd5;
  localparam logic [SCORE_W-1:0] TURN_THR_RST  = 16'd58982;

  // One closed frame pushed into the class/score history.
  typedef struct packed {
    logic               en;
    logic [CLS_W-1:0]   cls;
    logic [SCORE_W-1:0] score;
  } hist_push_t;

  // One turn score pushed into the turn history.
  typedef struct packed {
    logic               en;
    logic [SCORE_W-1:0] score;
  } turn_push_t;

endpackage

`default_nettype wire

>>> rtl/cvs_in_if.sv
`default_nettype none

interface cvs_in_if;
  logic                        valid;
  logic                        ready;
  logic [cvs_pkg::SCORE_W-1:0] class_score;
  logic                        frame_last;
  logic [cvs_pkg::SCORE_W-1:0] turn_score;

  modport source (output valid, class_score, frame_last, turn_score, input ready);
  modport sink (input valid, class_score, frame_last, turn_score, output ready);
endinterface

`default_nettype wire

>>> rtl/cvs_out_if.sv
`default_nettype none

interface cvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [cvs_pkg::CLS_W-1:0]   best_class;
  logic                        class_valid;
  logic [cvs_pkg::SCORE_W-1:0] class_confidence;
  logic                        turn_detected;
  logic [cvs_pkg::SCORE_W-1:0] turn_avg;

  modport source (output valid, best_class, class_valid, class_confidence, turn_detected,
                  turn_avg, input ready);
  modport sink (input valid, best_class, class_valid, class_confidence, turn_detected,
                turn_avg, output ready);
endinterface

`default_nettype wire

>>> rtl/cvs_divider.sv
`default_nettype none

module cvs_divider #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign trial   = shifted - {1'b0, den_r};

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/cvs_hist_vote.sv
`default_nettype none

module cvs_hist_vote #(
  parameter int HISTORY_DEPTH = 16,
  parameter int VOTE_WINDOW   = 8,
  localparam int CNT_W        = $clog2(VOTE_WINDOW + 1),
  localparam int SUM_W        = cvs_pkg::SCORE_W + CNT_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cvs_pkg::hist_push_t          push,
  output logic                              done,
  output logic [cvs_pkg::CLS_W-1:0]         win_cls,
  output logic [CNT_W-1:0]                  win_cnt,
  output logic [SUM_W-1:0]                  win_sum
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int LW    = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
  localparam int ENT_W = cvs_pkg::CLS_W + cvs_pkg::SCORE_W;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] WIN_N    = CNT_W'(VOTE_WINDOW);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_SEL  = 2'd2;

  logic [ENT_W-1:0]         mem_r [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] ent_vld_r;
  logic [PTR_W-1:0]         ptr_r;
  logic [PTR_W-1:0]         wr_ptr;
  logic [1:0]               ph_r;
  logic                     done_r;

  logic [PTR_W-1:0]         rd_addr_r;
  logic [CNT_W-1:0]         rd_cnt_r;
  logic [ENT_W-1:0]         rd_data_r;
  logic                     rd_ok_r;
  logic                     rd_vld_r;
  logic [LW-1:0]            rd_k_r;
  logic [cvs_pkg::CLS_W-1:0]   rd_cls;
  logic [cvs_pkg::SCORE_W-1:0] rd_scr;

  logic [cvs_pkg::CLS_W-1:0] lane_cls_r [VOTE_WINDOW];
  logic [CNT_W-1:0]          lane_cnt_r [VOTE_WINDOW];
  logic [SUM_W-1:0]          lane_sum_r [VOTE_WINDOW];

  logic [CNT_W-1:0]          sel_cnt_r;
  logic [cvs_pkg::CLS_W-1:0] s_cls;
  logic [CNT_W-1:0]          s_cnt;
  logic [SUM_W-1:0]          s_sum;
  logic [cvs_pkg::CLS_W-1:0] best_cls_r;
  logic [CNT_W-1:0]          best_cnt_r;
  logic [SUM_W-1:0]          best_sum_r;

  // Slot of the entry being pushed, wrapping at the end of the ring.
  assign wr_ptr = (ptr_r == LAST_IDX) ? '0 : ptr_r + PTR_W'(1);

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push.en) begin
      mem_r[wr_ptr] <= {push.cls, push.score};
    end
    rd_data_r <= mem_r[rd_addr_r];
    rd_ok_r   <= ent_vld_r[rd_addr_r];
  end

  // An entry never written since reset reads as class 0, score 0.
  assign rd_cls = rd_ok_r ? rd_data_r[ENT_W-1:cvs_pkg::SCORE_W] : '0;
  assign rd_scr = rd_ok_r ? rd_data_r[cvs_pkg::SCORE_W-1:0] : '0;

  // Lane currently offered to the winner search.
  assign s_cls = lane_cls_r[sel_cnt_r[LW-1:0]];
  assign s_cnt = lane_cnt_r[sel_cnt_r[LW-1:0]];
  assign s_sum = lane_sum_r[sel_cnt_r[LW-1:0]];

  // Sequencer: push, walk the window backward, then pick the winner.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      ptr_r     <= '0;
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      rd_cnt_r  <= '0;
      sel_cnt_r <= '0;
      done_r    <= 1'b0;
    end else begin
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
          if (push.en) begin
            ptr_r             <= wr_ptr;
            ent_vld_r[wr_ptr] <= 1'b1;
            rd_addr_r         <= wr_ptr;
            rd_cnt_r          <= '0;
            ph_r              <= PH_READ;
          end
        end
        PH_READ: begin
          if (rd_cnt_r != WIN_N) begin
            rd_vld_r  <= 1'b1;
            rd_k_r    <= rd_cnt_r[LW-1:0];
            rd_addr_r <= (rd_addr_r == '0) ? LAST_IDX : rd_addr_r - PTR_W'(1);
            rd_cnt_r  <= rd_cnt_r + CNT_W'(1);
          end else begin
            sel_cnt_r  <= '0;
            best_cls_r <= '0;
            best_cnt_r <= '0;
            best_sum_r <= '0;
            ph_r       <= PH_SEL;
          end
        end
        PH_SEL: begin
          if (sel_cnt_r != WIN_N) begin
            // Most votes wins; on equal votes the lower class index wins.
            if ((s_cnt > best_cnt_r) || ((s_cnt == best_cnt_r) && (s_cls < best_cls_r))) begin
              best_cls_r <= s_cls;
              best_cnt_r <= s_cnt;
              best_sum_r <= s_sum;
            end
            sel_cnt_r <= sel_cnt_r + CNT_W'(1);
          end else begin
            done_r <= 1'b1;
            ph_r   <= PH_IDLE;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  // Vote lanes: lane k opens on window entry k and then counts every later
  // entry of the same class. The lane of a class's first entry ends up with
  // the full count and sum; later lanes of that class always hold fewer.
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int j = 0; j < VOTE_WINDOW; j++) begin
        if (LW'(j) == rd_k_r) begin
          lane_cls_r[j] <= rd_cls;
          lane_cnt_r[j] <= CNT_W'(1);
          lane_sum_r[j] <= SUM_W'(rd_scr);
        end else if (lane_cls_r[j] == rd_cls) begin
          lane_cnt_r[j] <= lane_cnt_r[j] + CNT_W'(1);
          lane_sum_r[j] <= lane_sum_r[j] + SUM_W'(rd_scr);
        end
      end
    end
  end

  assign done    = done_r;
  assign win_cls = best_cls_r;
  assign win_cnt = best_cnt_r;
  assign win_sum = best_sum_r;

endmodule

`default_nettype wire

>>> rtl/cvs_turn_win.sv
`default_nettype none

module cvs_turn_win #(
  parameter int TURN_HISTORY_DEPTH = 8,
  parameter int TURN_WINDOW        = 4,
  localparam int TSUM_W            = cvs_pkg::SCORE_W + $clog2(TURN_WINDOW + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cvs_pkg::turn_push_t         push,
  input  wire logic [cvs_pkg::SCORE_W-1:0] thr,
  output logic                             done,
  output logic [TSUM_W-1:0]                tsum,
  output logic                             all_above
);

  localparam int PTR_W = $clog2(TURN_HISTORY_DEPTH);
  localparam int TC_W  = $clog2(TURN_WINDOW + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TURN_HISTORY_DEPTH - 1);
  localparam logic [TC_W-1:0]  WIN_N    = TC_W'(TURN_WINDOW);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_READ = 1'b1;

  logic [cvs_pkg::SCORE_W-1:0] mem_r [TURN_HISTORY_DEPTH];
  logic [TURN_HISTORY_DEPTH-1:0] ent_vld_r;
  logic [PTR_W-1:0]            ptr_r;
  logic [PTR_W-1:0]            wr_ptr;
  logic                        ph_r;
  logic                        done_r;
  logic [PTR_W-1:0]            rd_addr_r;
  logic [TC_W-1:0]             rd_cnt_r;
  logic [cvs_pkg::SCORE_W-1:0] rd_data_r;
  logic                        rd_ok_r;
  logic                        rd_vld_r;
  logic [cvs_pkg::SCORE_W-1:0] rd_val;
  logic [TSUM_W-1:0]           tsum_r;
  logic                        all_r;

  assign wr_ptr = (ptr_r == LAST_IDX) ? '0 : ptr_r + PTR_W'(1);

  // Turn history memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push.en) begin
      mem_r[wr_ptr] <= push.score;
    end
    rd_data_r <= mem_r[rd_addr_r];
    rd_ok_r   <= ent_vld_r[rd_addr_r];
  end

  assign rd_val = rd_ok_r ? rd_data_r : '0;

  // Push, then read the newest entries backward and accumulate them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      ptr_r     <= '0;
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      rd_cnt_r  <= '0;
      done_r    <= 1'b0;
    end else begin
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
          if (push.en) begin
            ptr_r             <= wr_ptr;
            ent_vld_r[wr_ptr] <= 1'b1;
            rd_addr_r         <= wr_ptr;
            rd_cnt_r          <= '0;
            tsum_r            <= '0;
            all_r             <= 1'b1;
            ph_r              <= PH_READ;
          end
        end
        PH_READ: begin
          if (rd_cnt_r != WIN_N) begin
            rd_vld_r  <= 1'b1;
            rd_addr_r <= (rd_addr_r == '0) ? LAST_IDX : rd_addr_r - PTR_W'(1);
            rd_cnt_r  <= rd_cnt_r + TC_W'(1);
          end else begin
            done_r <= 1'b1;
            ph_r   <= PH_IDLE;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
      // The read of the last entry lands together with the done pulse.
      if (rd_vld_r) begin
        tsum_r <= tsum_r + TSUM_W'(rd_val);
        if (!(rd_val > thr)) begin
          all_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign tsum      = tsum_r;
  assign all_above = all_r;

endmodule

`default_nettype wire

>>> rtl/classifier_vote_smoother.sv
`default_nettype none

// Smooths a per-frame classifier: each word carries one class score (Q0.16) in
// class order, and the word with frame_last set closes the frame and carries its
// turn score. Words inside a frame are taken one per cycle and only update the
// running argmax. The closing word pushes the frame's class and score into the
// history memory and its turn score into the turn memory, and the block then
// accepts nothing until its result is formed. The vote pass and the turn pass run
// side by side, each through the single read port of its memory. The longer of the
// two is followed by a one-bit-per-cycle divider for the mean score, one quotient bit
// for each bit of the vote sum (16 + $clog2(VOTE_WINDOW + 1) bits). The turn average
// comes from a constant reciprocal multiply. One result word comes out per frame;
// it sits in an output register, so the next frame may start while it waits to be
// taken, but a closing word whose result finds that register still full keeps the
// input held until it is free. Both history memories start out reading as zero
// through per-entry valid bits, so no clearing pass follows reset.
module classifier_vote_smoother #(
  parameter int NUM_CLASSES        = 64,
  parameter int HISTORY_DEPTH      = 16,
  parameter int VOTE_WINDOW        = 8,
  parameter int TURN_HISTORY_DEPTH = 8,
  parameter int TURN_WINDOW        = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cvs_in_if.sink                              in_word,
  cvs_out_if.source                           out_word,
  input  wire logic                           cfg_we,
  input  wire logic [cvs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [cvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(VOTE_WINDOW + 1);
  localparam int SUM_W  = cvs_pkg::SCORE_W + CNT_W;
  localparam int TC_W   = $clog2(TURN_WINDOW + 1);
  localparam int TSUM_W = cvs_pkg::SCORE_W + TC_W;
  localparam int MVC_W  = (CNT_W > cvs_pkg::MV_W) ? CNT_W : cvs_pkg::MV_W;
  localparam logic [cvs_pkg::CLS_W-1:0] LAST_CLS = cvs_pkg::CLS_W'(NUM_CLASSES - 1);

  // Rounded-up reciprocal of TURN_WINDOW; the shift is wide enough that the
  // product gives the exact floor for every possible turn sum.
  localparam int TQ_SH = TSUM_W + TC_W;
  localparam int RCP_W = TQ_SH + 1;
  localparam int TP_W  = TSUM_W + RCP_W;
  localparam logic [RCP_W-1:0] TURN_RCP =
    RCP_W'(((64'd1 << TQ_SH) + 64'(TURN_WINDOW) - 64'd1) / 64'(TURN_WINDOW));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VOTE = 3'd1;
  localparam logic [2:0] ST_DIVM = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0] state_r;
  logic       in_acc;

  logic [cvs_pkg::SCORE_W-1:0] loc_thr_r;
  logic [cvs_pkg::MV_W-1:0]    min_votes_r;
  logic [cvs_pkg::SCORE_W-1:0] turn_thr_r;

  logic [cvs_pkg::CLS_W-1:0]   class_counter_r;
  logic [cvs_pkg::SCORE_W-1:0] running_max_r;
  logic [cvs_pkg::CLS_W-1:0]   current_class_r;
  logic [cvs_pkg::SCORE_W-1:0] last_score_r;
  logic                        score_gt;
  logic [cvs_pkg::CLS_W-1:0]   cls_now;
  logic [cvs_pkg::SCORE_W-1:0] max_now;
  logic [cvs_pkg::SCORE_W-1:0] frame_score;

  cvs_pkg::hist_push_t hist_push;
  cvs_pkg::turn_push_t turn_push;

  logic                      hv_done;
  logic [cvs_pkg::CLS_W-1:0] win_cls;
  logic [CNT_W-1:0]          win_cnt;
  logic [SUM_W-1:0]          win_sum;
  logic                      tw_done;
  logic [TSUM_W-1:0]         tsum;
  logic                      all_above;
  logic                      h_done_r;
  logic                      t_done_r;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [TP_W-1:0]  turn_prod;

  logic [SUM_W-1:0]            thr_prod;
  logic                        cls_ok;
  logic                        cls_ok_r;
  logic [cvs_pkg::SCORE_W-1:0] mean_r;
  logic [cvs_pkg::SCORE_W-1:0] tconf_r;

  logic                        out_valid_r;
  logic [cvs_pkg::CLS_W-1:0]   out_cls_r;
  logic                        out_cvld_r;
  logic [cvs_pkg::SCORE_W-1:0] out_cconf_r;
  logic                        out_turn_r;
  logic [cvs_pkg::SCORE_W-1:0] out_tconf_r;

  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_thr_r   <= cvs_pkg::LOC_THR_RST;
      min_votes_r <= cvs_pkg::MIN_VOTES_RST;
      turn_thr_r  <= cvs_pkg::TURN_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cvs_pkg::REG_LOC_THR:   loc_thr_r   <= cfg_wdata;
        cvs_pkg::REG_MIN_VOTES: min_votes_r <= cfg_wdata[cvs_pkg::MV_W-1:0];
        cvs_pkg::REG_TURN_THR:  turn_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Running argmax of the frame; an equal score does not displace the leader.
  assign score_gt    = in_word.class_score > running_max_r;
  assign cls_now     = score_gt ? class_counter_r : current_class_r;
  assign max_now     = score_gt ? in_word.class_score : running_max_r;
  // A frame with no score above zero repeats the score pushed last.
  assign frame_score = (max_now != '0) ? max_now : last_score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_counter_r <= '0;
      running_max_r   <= '0;
      current_class_r <= '0;
      last_score_r    <= '0;
    end else if (in_acc) begin
      current_class_r <= cls_now;
      if (in_word.frame_last) begin
        class_counter_r <= '0;
        running_max_r   <= '0;
        last_score_r    <= frame_score;
      end else begin
        running_max_r <= max_now;
        // Extra scores of an overlong frame all compete as the last class.
        if (class_counter_r < LAST_CLS) begin
          class_counter_r <= class_counter_r + cvs_pkg::CLS_W'(1);
        end
      end
    end
  end

  // The closing word pushes into both histories and starts their window passes.
  always_comb begin
    hist_push.en    = in_acc && in_word.frame_last;
    hist_push.cls   = cls_now;
    hist_push.score = frame_score;
    turn_push.en    = in_acc && in_word.frame_last;
    turn_push.score = in_word.turn_score;
  end

  cvs_hist_vote #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .VOTE_WINDOW   (VOTE_WINDOW)
  ) u_hist_vote (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (hist_push),
    .done    (hv_done),
    .win_cls (win_cls),
    .win_cnt (win_cnt),
    .win_sum (win_sum)
  );

  cvs_turn_win #(
    .TURN_HISTORY_DEPTH (TURN_HISTORY_DEPTH),
    .TURN_WINDOW        (TURN_WINDOW)
  ) u_turn_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (turn_push),
    .thr       (turn_thr_r),
    .done      (tw_done),
    .tsum      (tsum),
    .all_above (all_above)
  );

  // More votes than the minimum and exact mean test: sum > threshold * count, before the mean is truncated.
  assign thr_prod = SUM_W'(loc_thr_r) * SUM_W'(win_cnt);
  assign cls_ok   = (MVC_W'(win_cnt) > MVC_W'(min_votes_r)) && (win_sum > thr_prod);

  // The divider forms the mean score once both window passes are done.
  assign div_start = (state_r == ST_VOTE) && h_done_r && t_done_r;

  cvs_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (win_sum),
    .den   (win_cnt),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Turn average: multiply by the reciprocal and keep the integer part.
  assign turn_prod = TP_W'(tsum) * TP_W'(TURN_RCP);

  // Frame-end sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      h_done_r <= 1'b0;
      t_done_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_word.frame_last) begin
            state_r <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          if (hv_done) begin
            h_done_r <= 1'b1;
          end
          if (tw_done) begin
            t_done_r <= 1'b1;
          end
          if (h_done_r && t_done_r) begin
            h_done_r <= 1'b0;
            t_done_r <= 1'b0;
            cls_ok_r <= cls_ok;
            state_r  <= ST_DIVM;
          end
        end
        ST_DIVM: begin
          if (div_done) begin
            mean_r  <= div_quo[cvs_pkg::SCORE_W-1:0];
            tconf_r <= turn_prod[TQ_SH +: cvs_pkg::SCORE_W];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_word.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: loaded once the previous word has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && (!out_valid_r || out_word.ready)) begin
      out_valid_r <= 1'b1;
      out_cls_r   <= win_cls;
      out_cvld_r  <= cls_ok_r;
      out_cconf_r <= cls_ok_r ? mean_r : '0;
      out_turn_r  <= all_above;
      out_tconf_r <= tconf_r;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_word.valid            = out_valid_r;
  assign out_word.best_class       = out_cls_r;
  assign out_word.class_valid      = out_cvld_r;
  assign out_word.class_confidence = out_cconf_r;
  assign out_word.turn_detected    = out_turn_r;
  assign out_word.turn_avg         = out_tconf_r;

endmodule

`default_nettype wire

>>> rtl/cvs_checker.sv
`default_nettype none

module cvs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        frame_last,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        class_valid,
  input wire logic [cvs_pkg::SCORE_W-1:0] class_confidence
);

  // A pending result word is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A word that closes a frame keeps the input stalled while the vote runs.
  a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && frame_last |=> !in_ready)
    else $error("input taken during frame-end processing");

  // A new result only appears at the end of frame-end processing.
  a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without frame-end processing");

  // A rejected vote reports zero confidence.
  a_conf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !class_valid |-> class_confidence == '0)
    else $error("confidence nonzero on invalid class");

endmodule

bind classifier_vote_smoother cvs_checker u_cvs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_word.valid),
  .in_ready         (in_word.ready),
  .frame_last       (in_word.frame_last),
  .out_valid        (out_word.valid),
  .out_ready        (out_word.ready),
  .class_valid      (out_word.class_valid),
  .class_confidence (out_word.class_confidence)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CLS_W      = cvs_pkg::CLS_W;
  localparam int SCORE_W    = cvs_pkg::SCORE_W;
  localparam int MV_W       = cvs_pkg::MV_W;
  localparam int CFG_IDX_W  = cvs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = cvs_pkg::CFG_DATA_W;

  localparam int CLASSES      = 64;
  localparam int WINDOW       = 8;
  localparam int TURN_WIN     = 4;
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE       = 80;
  localparam int END_SLACK    = 100;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 50;

  // One result word as the block reports it.
  typedef struct packed {
    logic [CLS_W-1:0]   best_class;
    logic               class_valid;
    logic [SCORE_W-1:0] class_confidence;
    logic               turn_detected;
    logic [SCORE_W-1:0] turn_avg;
  } vote_word_t;

  // One row of the directed table; some rows carry a hand-written result.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
    logic [SCORE_W-1:0] turn;
    logic               pinned;
    vote_word_t         want;
  } frame_row_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cvs_in_if  in_if ();
  cvs_out_if out_if ();

  classifier_vote_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_if),
    .out_word  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Mirror of the block's registers and history.
  logic [SCORE_W-1:0] loc_thr;
  logic [MV_W-1:0]    vote_floor;
  logic [SCORE_W-1:0] turn_thr;
  logic [CLS_W-1:0]   frame_pos;
  logic [SCORE_W-1:0] frame_peak;
  logic [CLS_W-1:0]   peak_class;
  logic [CLS_W-1:0]   cls_ring [16];
  logic [SCORE_W-1:0] score_ring [16];
  logic [3:0]         ring_head;
  logic [SCORE_W-1:0] turn_ring [8];
  logic [2:0]         turn_head;

  vote_word_t  expected_votes [$];
  bit          pin_next;
  vote_word_t  pinned_vote;
  bit          hold_req;
  int unsigned burst_left;
  int unsigned fav_class;
  int unsigned mismatches, words_in, frames_out, valid_votes, turns_seen, long_frames;

  // Directed frames: empty frame after reset, full-scale peak, ties, a frame with
  // no score above zero, then a run of full-scale single-word frames.
  frame_row_t directed_rows [0:21] = '{
    '{16'h0000, 1'b1, 16'h0000, 1'b1, '{6'd0, 1'b0, 16'd0, 1'b0, 16'd0}},
    '{16'hFFFF, 1'b0, 16'hFFFF, 1'b0, '0},
    '{16'h1234, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'h0001, 1'b0, 16'h0000, 1'b0, '0},
    '{16'h0001, 1'b0, 16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, 16'h0000, 1'b0, '0},
    '{16'h8000, 1'b0, 16'h5555, 1'b0, '0},
    '{16'h8000, 1'b0, 16'hAAAA, 1'b0, '0},
    '{16'h7FFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, 16'h0000, 1'b0, '0},
    '{16'h0000, 1'b1, 16'hFFFF, 1'b1, '{6'd0, 1'b0, 16'd0, 1'b1, 16'hFFFF}},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'h0000, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hE667, 1'b0, '0},
    '{16'hFFFF, 1'b1, 16'hE666, 1'b0, '0}
  };

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // Track the argmax of the open frame; on the closing word push the frame,
  // vote over the window and average the recent turn scores.
  task automatic predict_frame_vote(input logic [SCORE_W-1:0] score, input logic last,
                                    input logic [SCORE_W-1:0] turn);
    int unsigned tally [CLASSES];
    int unsigned total [CLASSES];
    logic [SCORE_W-1:0] kept_score;
    logic [3:0] slot;
    logic [2:0] tslot;
    int unsigned top, top_count, turn_sum;
    logic pass_all;
    vote_word_t v;
    if (score > frame_peak) begin
      frame_peak = score;
      peak_class = frame_pos;
    end
    if (!last) begin
      if (frame_pos < CLASSES - 1) frame_pos++;
    end else begin
      // A frame with nothing above zero repeats the last pushed score.
      kept_score = (frame_peak != 0) ? frame_peak : score_ring[ring_head];
      ring_head++;
      cls_ring[ring_head] = peak_class;
      score_ring[ring_head] = kept_score;
      frame_pos = '0;
      frame_peak = '0;

      foreach (tally[i]) begin
        tally[i] = 0;
        total[i] = 0;
      end
      slot = ring_head;
      for (int i = 0; i < WINDOW; i++) begin
        tally[cls_ring[slot]]++;
        total[cls_ring[slot]] += score_ring[slot];
        slot--;
      end
      // Strict compare keeps the lowest class on a tie.
      top = 0;
      top_count = 0;
      for (int i = 0; i < CLASSES; i++) begin
        if (tally[i] > top_count) begin
          top_count = tally[i];
          top = i;
        end
      end
      v = '0;
      v.best_class = top[CLS_W-1:0];
      if (top_count != 0) begin
        v.class_valid = (top_count > vote_floor) &&
                        (64'(total[top]) > 64'(loc_thr) * 64'(top_count));
        if (v.class_valid) v.class_confidence = SCORE_W'(total[top] / top_count);
      end

      turn_head++;
      turn_ring[turn_head] = turn;
      tslot = turn_head;
      turn_sum = 0;
      pass_all = 1'b1;
      for (int i = 0; i < TURN_WIN; i++) begin
        if (!(turn_ring[tslot] > turn_thr)) pass_all = 1'b0;
        turn_sum += turn_ring[tslot];
        tslot--;
      end
      v.turn_detected = pass_all;
      v.turn_avg = SCORE_W'(turn_sum / TURN_WIN);

      if (pin_next) begin
        expected_votes.push_back(pinned_vote);
        pin_next = 1'b0;
      end else begin
        expected_votes.push_back(v);
      end
    end
  endtask

  // Result words are checked first, then the accepted input word is predicted.
  always @(posedge clk) begin : monitor
    vote_word_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.best_class, out_if.class_valid, out_if.class_confidence,
              out_if.turn_detected, out_if.turn_avg};
      frames_out++;
      if (got.class_valid) valid_votes++;
      if (got.turn_detected) turns_seen++;
      if (expected_votes.size() == 0) begin
        report_mismatch("unexpected result word", '0, got[31:0]);
      end else begin
        want = expected_votes.pop_front();
        if (got.best_class !== want.best_class)
          report_mismatch("best_class", 32'(want.best_class), 32'(got.best_class));
        if (got.class_valid !== want.class_valid)
          report_mismatch("class_valid", 32'(want.class_valid), 32'(got.class_valid));
        if (got.class_confidence !== want.class_confidence)
          report_mismatch("class_confidence", 32'(want.class_confidence),
                          32'(got.class_confidence));
        if (got.turn_detected !== want.turn_detected)
          report_mismatch("turn_detected", 32'(want.turn_detected), 32'(got.turn_detected));
        if (got.turn_avg !== want.turn_avg)
          report_mismatch("turn_avg", 32'(want.turn_avg), 32'(got.turn_avg));
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      words_in++;
      predict_frame_vote(in_if.class_score, in_if.frame_last, in_if.turn_score);
    end
  end

  // Offer one word at the falling edge, hold it until taken, then maybe pause.
  task automatic send_word(input logic [SCORE_W-1:0] score, input logic last,
                           input logic [SCORE_W-1:0] turn);
    in_if.valid       <= 1'b1;
    in_if.class_score <= score;
    in_if.frame_last  <= last;
    in_if.turn_score  <= turn;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (expected_votes.size() != 0);
  endtask

  // Registers are only written with the block idle.
  task automatic configure(input logic [SCORE_W-1:0] loc, input logic [MV_W-1:0] votes,
                           input logic [SCORE_W-1:0] turn);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= cvs_pkg::REG_LOC_THR;
    cfg_wdata <= loc;
    loc_thr = loc;
    @(negedge clk);
    cfg_idx   <= cvs_pkg::REG_MIN_VOTES;
    cfg_wdata <= CFG_DATA_W'(votes);
    vote_floor = votes;
    @(negedge clk);
    cfg_idx   <= cvs_pkg::REG_TURN_THR;
    cfg_wdata <= turn;
    turn_thr = turn;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly frames with a persistent favored class so votes can pass, mixed
  // with empty frames, over-length frames and pure noise.
  task automatic random_frames(input int unsigned word_budget);
    int unsigned sent, len, kind, hot;
    logic [SCORE_W-1:0] s, t;
    sent = 0;
    while (sent < word_budget) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 15)
        fav_class = ($urandom_range(0, 19) == 0) ? $urandom_range(0, CLASSES - 1)
                                                 : $urandom_range(0, 7);
      if (kind < 5) begin
        len = $urandom_range(1, 6);
      end else if (kind < 9) begin
        len = $urandom_range(CLASSES - 4, CLASSES + 6);
        long_frames++;
      end else begin
        len = $urandom_range(1, 8);
        if (len <= fav_class) len = fav_class + 1;
      end
      hot = (kind < 9) ? $urandom_range(CLASSES - 2, len - 1) : fav_class;
      for (int i = 0; i < len; i++) begin
        if (kind < 5)
          s = '0;
        else if (kind < 9)
          s = (i == hot) ? SCORE_W'($urandom_range(50000, 65535))
                         : SCORE_W'($urandom_range(0, 49999));
        else if (kind < 20)
          s = SCORE_W'($urandom_range(0, 65535));
        else if (i == hot)
          s = SCORE_W'($urandom_range(52000, 65535));
        else
          s = ($urandom_range(0, 3) == 0) ? '0 : SCORE_W'($urandom_range(0, 51999));
        t = ($urandom_range(0, 1) == 0) ? SCORE_W'($urandom_range(55000, 65535))
                                        : SCORE_W'($urandom_range(0, 65535));
        send_word(s, i == len - 1, t);
        sent++;
      end
    end
  endtask

  // Result side: stall patterns that change at random, plus one long hold-off on
  // request.
  initial begin : receiver
    rx_mode_t mode;
    int unsigned seg, tick;
    out_if.ready = 1'b0;
    mode = RX_OPEN;
    seg = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        if (seg == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg = $urandom_range(20, 200);
        end
        seg--;
        tick++;
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.class_score = '0;
    in_if.frame_last = 1'b0;
    in_if.turn_score = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    loc_thr = cvs_pkg::LOC_THR_RST;
    vote_floor = cvs_pkg::MIN_VOTES_RST;
    turn_thr = cvs_pkg::TURN_THR_RST;
    frame_pos = '0;
    frame_peak = '0;
    peak_class = '0;
    ring_head = '0;
    turn_head = '0;
    foreach (cls_ring[i]) begin
      cls_ring[i] = '0;
      score_ring[i] = '0;
    end
    foreach (turn_ring[i]) turn_ring[i] = '0;
    pin_next = 1'b0;
    pinned_vote = '0;
    hold_req = 1'b0;
    burst_left = $urandom_range(1, 48);
    fav_class = 0;
    mismatches = 0;
    words_in = 0;
    frames_out = 0;
    valid_votes = 0;
    turns_seen = 0;
    long_frames = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table under the reset settings.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].pinned) begin
        pin_next = 1'b1;
        pinned_vote = directed_rows[r].want;
      end
      send_word(directed_rows[r].score, directed_rows[r].last, directed_rows[r].turn);
    end
    random_frames(200);

    // Lowest settings: all thresholds zero, so any score above zero passes them.
    configure('0, '0, '0);
    random_frames(250);

    // Highest settings, with the result side held off for a long stretch.
    configure(16'hFFFF, 4'd8, 16'hFFFF);
    hold_req = 1'b1;
    random_frames(250);

    // Random settings, with a full pause halfway.
    configure(SCORE_W'($urandom_range(0, 65535)), MV_W'($urandom_range(0, 8)),
              SCORE_W'($urandom_range(0, 65535)));
    random_frames(130);
    wait_drained();
    random_frames(130);

    configure(16'd30000, 4'd2, 16'd40000);
    random_frames(250);

    configure(cvs_pkg::LOC_THR_RST, cvs_pkg::MIN_VOTES_RST, cvs_pkg::TURN_THR_RST);
    random_frames(250);

    wait_drained();
    repeat (END_SLACK) @(negedge clk);
    $display("Run covered %0d words in %0d frames (%0d over-length) across six settings.",
             words_in, frames_out, long_frames);
    $display("Votes passed thresholds %0d times, turns flagged %0d times, %0d mismatches.",
             valid_votes, turns_seen, mismatches);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
